FILE: rtl/core/ladsr_pkg.sv
package ladsr_pkg;

    localparam int DEF_VOICES    = 16;
    localparam int DEF_FRAC_BITS = 32;

    localparam int OUT_FRAC    = 24;
    localparam int TIME_W      = 24;
    localparam int FAST_W      = 16;
    localparam int PCT_W       = 7;
    localparam int MODE_W      = 2;
    localparam int VOICE_W     = 4;
    localparam int STAGE_W     = 3;
    localparam int LEVEL_OUT_W = 25;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int PCT_FULL    = 100;

    localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FAST = 2'd3;

    localparam logic [STAGE_W-1:0] ST_OFF     = 3'd0;
    localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
    localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd2;
    localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd3;
    localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd4;
    localparam logic [STAGE_W-1:0] ST_FAST    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST    = 3'd4;

    localparam logic [TIME_W-1:0] RST_ATTACK  = 24'd441;
    localparam logic [TIME_W-1:0] RST_DECAY   = 24'd441;
    localparam logic [PCT_W-1:0]  RST_SUSTAIN = 7'd100;
    localparam logic [TIME_W-1:0] RST_RELEASE = 24'd441;
    localparam logic [FAST_W-1:0] RST_FAST    = 16'd64;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: rtl/core/ladsr_div.sv
module ladsr_div
    import ladsr_pkg::*;
#(
    parameter int NUM_W = DEF_FRAC_BITS + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [TIME_W-1:0] i_den,
    output logic [NUM_W-1:0]  o_quo,
    output logic              o_rem_nz,
    output t_div_stat         o_stat
);

    localparam int CW = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [NUM_W-1:0]  r_q;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_den;

    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;
    logic              ge;
    logic [TIME_W-1:0] n_rem;

    // one quotient bit a cycle, restoring
    always_comb begin
        trial = {r_rem, r_q[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_quo       = r_q;
    assign o_rem_nz    = (r_rem != '0);
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: rtl/core/ladsr_voice_mem.sv
module ladsr_voice_mem
    import ladsr_pkg::*;
#(
    parameter int VOICES = DEF_VOICES,
    parameter int LW     = DEF_FRAC_BITS + 1,
    parameter int AW     = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [STAGE_W-1:0] o_rd_stage,
    output logic [LW-1:0]      o_rd_level,
    output logic [LW-1:0]      o_rd_step,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [STAGE_W-1:0] i_wr_stage,
    input  logic [LW-1:0]      i_wr_level,
    input  logic [LW-1:0]      i_wr_step
);

    localparam int EW = STAGE_W + 2 * LW;

    logic [EW-1:0]     r_mem [VOICES];
    logic [VOICES-1:0] r_vld;
    logic [EW-1:0]     r_rd_word;
    logic              r_rd_vld;

    // unwritten voices read as off, zero level, zero step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_stage, i_wr_level, i_wr_step};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_stage = r_rd_vld ? r_rd_word[EW-1 -: STAGE_W] : ST_OFF;
    assign o_rd_level = r_rd_vld ? r_rd_word[2*LW-1 -: LW] : '0;
    assign o_rd_step  = r_rd_vld ? r_rd_word[LW-1:0] : '0;

endmodule

FILE: rtl/core/linear_adsr_envelope_generator_top.sv
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+------------------------------
// cfg      | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
// in       | in        | i_in_valid / o_in_ready    | i_mode, i_voice
// out      | out       | o_out_valid / i_out_ready  | o_level, o_stage, o_active
//
// One word at a time. Ticks needing no new step and ignored note offs go through
// the read, execute and write-back steps. Note on, note off, fast release and the
// tick ending attack also wait on the serial divider, one quotient bit a cycle.
// Reset (sync, active low) makes every voice off; config writes always taken.
// A stalled output word holds the next result in the write-back step.
module linear_adsr_envelope_generator_top
    import ladsr_pkg::*;
#(
    parameter int VOICES    = DEF_VOICES,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [MODE_W-1:0]      i_mode,
    input  logic [VOICE_W-1:0]     i_voice,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [LEVEL_OUT_W-1:0] o_level,
    output logic [STAGE_W-1:0]     o_stage,
    output logic                   o_active
);

    localparam int LW      = FRAC_BITS + 1;
    localparam int NW      = FRAC_BITS + 1;
    localparam int AW      = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int DOWN_SH = (FRAC_BITS >= OUT_FRAC) ? (FRAC_BITS - OUT_FRAC) : 0;
    localparam int UP_SH   = (FRAC_BITS < OUT_FRAC) ? (OUT_FRAC - FRAC_BITS) : 0;
    localparam logic [LW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_EXEC  = 4'd2;
    localparam logic [3:0] S_STEP  = 4'd3;
    localparam logic [3:0] S_WB    = 4'd4;

    logic [3:0]         r_state, n_state;
    logic [MODE_W-1:0]  r_mode;
    logic [AW-1:0]      r_voice;
    logic               r_inr;
    logic [STAGE_W-1:0] r_stage, n_stage;
    logic [LW-1:0]      r_lvl, n_lvl;
    logic [LW-1:0]      r_stp, n_stp;

    logic [TIME_W-1:0]  r_att, r_dec, r_rel;
    logic [PCT_W-1:0]   r_pct;
    logic [FAST_W-1:0]  r_fst;

    logic                   r_o_valid;
    logic [LEVEL_OUT_W-1:0] r_o_level;
    logic [STAGE_W-1:0]     r_o_stage;
    logic                   r_o_active;

    logic               accept;
    logic               in_range;
    logic [AW+VOICE_W-1:0] voice_ext;
    logic [AW-1:0]      rd_addr;
    logic [STAGE_W-1:0] rd_stage;
    logic [LW-1:0]      rd_lvl;
    logic [LW-1:0]      rd_stp;
    logic               wr_en;
    logic               out_load;

    logic               div_start;
    logic [NW-1:0]      div_num;
    logic [TIME_W-1:0]  div_den;
    logic [NW-1:0]      div_quo;
    logic               div_rem_nz;
    t_div_stat          div_stat;

    logic [LW:0]        sum;
    logic [LW:0]        diff;
    logic [PCT_W-1:0]   pct_c;
    logic [TIME_W-1:0]  att_c, dec_c, rel_c, fst_c;
    logic [LW-1:0]      sus_tab [PCT_FULL+1];
    logic [LW-1:0]      sus_lvl;
    logic [LW+LEVEL_OUT_W-1:0] lvl_wide;

    assign accept    = i_in_valid && o_in_ready;
    assign voice_ext = {{AW{1'b0}}, i_voice};
    assign rd_addr   = voice_ext[AW-1:0];
    assign in_range  = ({{(32-VOICE_W){1'b0}}, i_voice} < 32'(VOICES));

    // zero times count as one sample, sustain clamps at full scale
    assign att_c = (r_att == '0) ? TIME_W'(1) : r_att;
    assign dec_c = (r_dec == '0) ? TIME_W'(1) : r_dec;
    assign rel_c = (r_rel == '0) ? TIME_W'(1) : r_rel;
    assign fst_c = (r_fst == '0) ? TIME_W'(1) : TIME_W'(r_fst);
    assign pct_c = (r_pct > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : r_pct;

    // sustain level per percent, floor(p * ONE / 100)
    for (genvar g = 0; g <= PCT_FULL; g++) begin : g_sus
        assign sus_tab[g] = LW'((64'(g) << FRAC_BITS) / 64'(PCT_FULL));
    end

    assign sus_lvl = sus_tab[pct_c];

    assign sum   = {1'b0, r_lvl} + {1'b0, r_stp};
    assign diff  = {1'b0, r_lvl} - {1'b0, r_stp};

    // config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att <= RST_ATTACK;
            r_dec <= RST_DECAY;
            r_pct <= RST_SUSTAIN;
            r_rel <= RST_RELEASE;
            r_fst <= RST_FAST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ATTACK:  r_att <= i_cfg_data;
                CFG_DECAY:   r_dec <= i_cfg_data;
                CFG_SUSTAIN: r_pct <= i_cfg_data[PCT_W-1:0];
                CFG_RELEASE: r_rel <= i_cfg_data;
                CFG_FAST:    r_fst <= i_cfg_data[FAST_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_stage   = r_stage;
        n_lvl     = r_lvl;
        n_stp     = r_stp;
        div_start = 1'b0;
        div_num   = NW'(ONE);
        div_den   = att_c;
        wr_en     = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_stage = rd_stage;
                n_lvl   = rd_lvl;
                n_stp   = rd_stp;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_WB;
                if (!r_inr) begin
                    n_stage = ST_OFF;
                    n_lvl   = '0;
                end else begin
                    case (r_mode)
                        MODE_TICK: begin
                            case (r_stage)
                                ST_ATTACK: begin
                                    if (sum > {1'b0, ONE}) begin
                                        n_lvl     = ONE;
                                        n_stage   = ST_DECAY;
                                        div_start = 1'b1;
                                        div_num   = NW'(ONE - sus_lvl);
                                        div_den   = dec_c;
                                        n_state   = S_STEP;
                                    end else begin
                                        n_lvl = sum[LW-1:0];
                                    end
                                end
                                ST_DECAY: begin
                                    if (diff[LW] || (diff[LW-1:0] < sus_lvl)) begin
                                        n_lvl   = sus_lvl;
                                        n_stage = ST_SUSTAIN;
                                    end else begin
                                        n_lvl = diff[LW-1:0];
                                    end
                                end
                                ST_RELEASE, ST_FAST: begin
                                    if (r_stp >= r_lvl) begin
                                        n_lvl   = '0;
                                        n_stage = ST_OFF;
                                    end else begin
                                        n_lvl = diff[LW-1:0];
                                    end
                                end
                                default: ;
                            endcase
                        end
                        MODE_ON: begin
                            n_lvl     = '0;
                            n_stage   = ST_ATTACK;
                            div_start = 1'b1;
                            div_num   = NW'(ONE);
                            div_den   = att_c;
                            n_state   = S_STEP;
                        end
                        MODE_OFF: begin
                            if (r_stage != ST_OFF) begin
                                n_stage   = ST_RELEASE;
                                div_start = 1'b1;
                                div_num   = NW'(r_lvl);
                                div_den   = rel_c;
                                n_state   = S_STEP;
                            end
                        end
                        default: begin
                            if (r_stage != ST_OFF) begin
                                n_stage   = ST_FAST;
                                div_start = 1'b1;
                                div_num   = NW'(r_lvl);
                                div_den   = fst_c;
                                n_state   = S_STEP;
                            end
                        end
                    endcase
                end
            end
            S_STEP: begin
                if (div_stat.done) begin
                    n_stp   = div_quo[LW-1:0] + LW'(div_rem_nz);
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (!r_o_valid || i_out_ready) begin
                    out_load = 1'b1;
                    wr_en    = r_inr;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_voice <= rd_addr;
            r_inr   <= in_range;
        end
        r_stage <= n_stage;
        r_lvl   <= n_lvl;
        r_stp   <= n_stp;
    end

    // output word
    assign lvl_wide = ({{LEVEL_OUT_W{1'b0}}, r_lvl} << UP_SH) >> DOWN_SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_level  <= lvl_wide[LEVEL_OUT_W-1:0];
            r_o_stage  <= r_stage;
            r_o_active <= (r_stage != ST_OFF);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_level     = r_o_level;
    assign o_stage     = r_o_stage;
    assign o_active    = r_o_active;

    ladsr_voice_mem #(
        .VOICES (VOICES),
        .LW     (LW),
        .AW     (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (rd_addr),
        .o_rd_stage (rd_stage),
        .o_rd_level (rd_lvl),
        .o_rd_step  (rd_stp),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_voice),
        .i_wr_stage (r_stage),
        .i_wr_level (r_lvl),
        .i_wr_step  (r_stp)
    );

    ladsr_div #(
        .NUM_W (NW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (div_num),
        .i_den    (div_den),
        .o_quo    (div_quo),
        .o_rem_nz (div_rem_nz),
        .o_stat   (div_stat)
    );

    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while idle");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_STEP))
        else $error("divider result with nobody waiting");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stage == ST_OFF) |-> (o_level == '0))
        else $error("off voice with nonzero level");

    a_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_level <= LEVEL_OUT_W'(1 << OUT_FRAC)))
        else $error("level above full scale");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

endmodule

FILE: verif/tb_linear_adsr_envelope_generator_top.sv
module tb_linear_adsr_envelope_generator_top;
    import ladsr_pkg::*;

    localparam logic [63:0] FX_ONE        = 64'd1 << DEF_FRAC_BITS;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          TAIL_WORDS    = 150;
    localparam int          HOLD_AT       = 400;
    localparam int          LONG_HOLD     = 300;
    localparam int          DRAIN_CYCLES  = 100;
    localparam int          PHASES        = 12;
    localparam int          PHASE_WORDS   = 105;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [LEVEL_OUT_W-1:0] level;
        logic [STAGE_W-1:0]     stage;
        logic                   active;
    } t_env_result;

    typedef struct {
        bit                    is_cfg;
        logic [MODE_W-1:0]     mode;
        logic [VOICE_W-1:0]    voice;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_env_op;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [MODE_W-1:0]      i_mode;
    logic [VOICE_W-1:0]     i_voice;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [LEVEL_OUT_W-1:0] o_level;
    logic [STAGE_W-1:0]     o_stage;
    logic                   o_active;

    linear_adsr_envelope_generator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_voice     (i_voice),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_level     (o_level),
        .o_stage     (o_stage),
        .o_active    (o_active)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // envelope state mirrored per voice
    logic [STAGE_W-1:0] env_stage [DEF_VOICES];
    logic [63:0]        env_level [DEF_VOICES];
    logic [63:0]        env_step  [DEF_VOICES];
    logic [TIME_W-1:0]  cfg_attack;
    logic [TIME_W-1:0]  cfg_decay;
    logic [PCT_W-1:0]   cfg_sustain;
    logic [TIME_W-1:0]  cfg_release;
    logic [FAST_W-1:0]  cfg_fast;

    t_env_op     pending_ops[$];
    t_env_result expected_results[$];
    int          total_words;
    int          words_sent;
    int          words_outstanding;
    int          results_taken;
    int          failures;
    int          idle_cycles;
    int          gap_left;
    int          stall_left;
    int          hold_left;
    bit          hold_done;

    function automatic logic [63:0] div_round_up(logic [63:0] num, logic [63:0] den);
        logic [63:0] d;
        d = (den == 64'd0) ? 64'd1 : den;
        return (num + d - 64'd1) / d;
    endfunction

    function automatic logic [63:0] sustain_fx();
        logic [63:0] p;
        p = (cfg_sustain > PCT_FULL) ? 64'(PCT_FULL) : 64'(cfg_sustain);
        return (p * FX_ONE) / 64'd100;
    endfunction

    function automatic t_env_result predict_envelope(logic [MODE_W-1:0] mode,
                                                     logic [VOICE_W-1:0] voice);
        logic [63:0] lvl;
        logic [63:0] st;
        logic [63:0] sus;
        t_env_result res;
        lvl = env_level[voice];
        st  = env_step[voice];
        case (mode)
            MODE_TICK: begin
                case (env_stage[voice])
                    ST_ATTACK: begin
                        lvl = lvl + st;
                        if (lvl > FX_ONE) begin
                            lvl              = FX_ONE;
                            env_stage[voice] = ST_DECAY;
                            env_step[voice]  = div_round_up(FX_ONE - sustain_fx(),
                                                            64'(cfg_decay));
                        end
                    end
                    ST_DECAY: begin
                        sus = sustain_fx();
                        if (lvl < st || lvl - st < sus) begin
                            lvl              = sus;
                            env_stage[voice] = ST_SUSTAIN;
                        end else begin
                            lvl = lvl - st;
                        end
                    end
                    ST_RELEASE, ST_FAST: begin
                        if (st >= lvl) begin
                            lvl              = 64'd0;
                            env_stage[voice] = ST_OFF;
                        end else begin
                            lvl = lvl - st;
                        end
                    end
                    default: begin
                    end
                endcase
                env_level[voice] = lvl;
            end
            MODE_ON: begin
                env_level[voice] = 64'd0;
                env_step[voice]  = div_round_up(FX_ONE, 64'(cfg_attack));
                env_stage[voice] = ST_ATTACK;
            end
            MODE_OFF: begin
                if (env_stage[voice] != ST_OFF) begin
                    env_stage[voice] = ST_RELEASE;
                    env_step[voice]  = div_round_up(env_level[voice], 64'(cfg_release));
                end
            end
            default: begin
                if (env_stage[voice] != ST_OFF) begin
                    env_stage[voice] = ST_FAST;
                    env_step[voice]  = div_round_up(env_level[voice], 64'(cfg_fast));
                end
            end
        endcase
        res.level  = LEVEL_OUT_W'(env_level[voice] >> (DEF_FRAC_BITS - OUT_FRAC));
        res.stage  = env_stage[voice];
        res.active = (env_stage[voice] != ST_OFF);
        return res;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ATTACK:  cfg_attack  = data[TIME_W-1:0];
            CFG_DECAY:   cfg_decay   = data[TIME_W-1:0];
            CFG_SUSTAIN: cfg_sustain = data[PCT_W-1:0];
            CFG_RELEASE: cfg_release = data[TIME_W-1:0];
            CFG_FAST:    cfg_fast    = data[FAST_W-1:0];
            default: begin
            end
        endcase
    endfunction

    task automatic push_word(logic [MODE_W-1:0] mode, logic [VOICE_W-1:0] voice);
        t_env_op op;
        op.is_cfg = 1'b0;
        op.mode   = mode;
        op.voice  = voice;
        op.idx    = '0;
        op.data   = '0;
        pending_ops.push_back(op);
        total_words++;
    endtask

    task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_env_op op;
        op.is_cfg = 1'b1;
        op.mode   = MODE_TICK;
        op.voice  = '0;
        op.idx    = idx;
        op.data   = data;
        pending_ops.push_back(op);
    endtask

    // mostly short times so that segments finish within a phase
    function automatic logic [CFG_DATA_W-1:0] pick_time(int unsigned max_val);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return CFG_DATA_W'(max_val);
        end else if (r == 2) begin
            return CFG_DATA_W'($urandom_range(1, max_val));
        end
        return CFG_DATA_W'($urandom_range(1, 12));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_sustain();
        int unsigned r;
        logic [PCT_W-1:0] pct;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            pct = '0;
        end else if (r == 1) begin
            pct = PCT_W'(PCT_FULL);
        end else if (r == 2) begin
            pct = PCT_W'($urandom_range(PCT_FULL + 1, 127));
        end else begin
            pct = PCT_W'($urandom_range(0, PCT_FULL));
        end
        return {(CFG_DATA_W - PCT_W)'($urandom), pct};
    endfunction

    // driver: input words and register writes
    always @(posedge i_clk) begin
        logic    in_v;
        logic    cfg_v;
        t_env_op op;
        if (i_rst_n) begin
            in_v  = i_in_valid;
            cfg_v = i_cfg_valid;
            if (o_out_valid && i_out_ready) begin
                words_outstanding--;
            end
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_envelope(i_mode, i_voice));
                words_outstanding++;
                words_sent++;
                in_v = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
                cfg_v = 1'b0;
            end
            if (words_outstanding == 0 && !in_v) begin
                idle_cycles++;
            end else begin
                idle_cycles = 0;
            end
            if (!in_v && !cfg_v && pending_ops.size() != 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_ops[0].is_cfg) begin
                    if (idle_cycles >= SETTLE_CYCLES) begin
                        op          = pending_ops.pop_front();
                        cfg_v       = 1'b1;
                        i_cfg_index <= op.idx;
                        i_cfg_data  <= op.data;
                    end
                end else if (words_sent + TAIL_WORDS < total_words &&
                             $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 5) - 1;
                end else begin
                    op      = pending_ops.pop_front();
                    in_v    = 1'b1;
                    i_mode  <= op.mode;
                    i_voice <= op.voice;
                end
            end
            i_in_valid  <= in_v;
            i_cfg_valid <= cfg_v;
        end
    end

    // monitor: result words and receiver back-pressure
    always @(posedge i_clk) begin
        t_env_result want;
        logic        rdy;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_taken++;
                if (expected_results.size() == 0) begin
                    $error("result word with no pending expectation: level %0d stage %0d",
                           o_level, o_stage);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_level !== want.level) begin
                        $error("level: expected %0d, actual %0d", want.level, o_level);
                        failures++;
                    end
                    if (o_stage !== want.stage) begin
                        $error("stage: expected %0d, actual %0d", want.stage, o_stage);
                        failures++;
                    end
                    if (o_active !== want.active) begin
                        $error("active: expected %0d, actual %0d", want.active, o_active);
                        failures++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && results_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                rdy       = 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (results_taken + TAIL_WORDS < total_words &&
                         $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                rdy        = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_out_ready <= rdy;
        end
    end

    initial begin
        logic [VOICE_W-1:0]    voice_set [4];
        int unsigned           set_size;
        int unsigned           r;
        logic [VOICE_W-1:0]    v;
        logic [CFG_DATA_W-1:0] fast_t;

        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_mode            = MODE_TICK;
        i_voice           = '0;
        i_out_ready       = 1'b0;
        total_words       = 0;
        words_sent        = 0;
        words_outstanding = 0;
        results_taken     = 0;
        failures          = 0;
        idle_cycles       = 0;
        gap_left          = 0;
        stall_left        = 0;
        hold_left         = 0;
        hold_done         = 1'b0;
        cfg_attack        = RST_ATTACK;
        cfg_decay         = RST_DECAY;
        cfg_sustain       = RST_SUSTAIN;
        cfg_release       = RST_RELEASE;
        cfg_fast          = RST_FAST;
        for (int k = 0; k < DEF_VOICES; k++) begin
            env_stage[k] = ST_OFF;
            env_level[k] = 64'd0;
            env_step[k]  = 64'd0;
        end

        // reset settings; releases on off voices are ignored; retrigger
        push_word(MODE_ON, 4'd0);
        push_word(MODE_TICK, 4'd0);
        push_word(MODE_TICK, 4'd0);
        push_word(MODE_OFF, 4'd1);
        push_word(MODE_FAST, 4'd2);
        push_word(MODE_TICK, 4'd1);
        push_word(MODE_OFF, 4'd0);
        push_word(MODE_TICK, 4'd0);
        push_word(MODE_FAST, 4'd0);
        push_word(MODE_TICK, 4'd0);
        push_word(MODE_ON, 4'd15);
        push_word(MODE_TICK, 4'd15);
        push_word(MODE_ON, 4'd15);

        // zero times act as one sample, sustain at zero, unused register index
        push_cfg(CFG_ATTACK, '0);
        push_cfg(CFG_DECAY, '0);
        push_cfg(CFG_SUSTAIN, '0);
        push_cfg(CFG_RELEASE, '0);
        push_cfg(CFG_FAST, '0);
        push_cfg(CFG_SPARE_HI, 24'hFFFFFF);
        push_word(MODE_ON, 4'd5);
        repeat (4) push_word(MODE_TICK, 4'd5);
        push_word(MODE_OFF, 4'd5);
        push_word(MODE_TICK, 4'd5);
        push_word(MODE_ON, 4'd10);
        push_word(MODE_TICK, 4'd10);
        push_word(MODE_FAST, 4'd10);
        push_word(MODE_TICK, 4'd10);
        push_word(MODE_TICK, 4'd10);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                // longest times, sustain above range
                push_cfg(CFG_ATTACK, 24'hFFFFFF);
                push_cfg(CFG_DECAY, 24'hFFFFFF);
                push_cfg(CFG_SUSTAIN, 24'hFFFFFF);
                push_cfg(CFG_RELEASE, 24'hFFFFFF);
                push_cfg(CFG_FAST, 24'hFFFFFF);
                push_cfg(CFG_SPARE_LO, 24'h000001);
            end else begin
                if (p == 1 || $urandom_range(0, 3) != 0) push_cfg(CFG_ATTACK, pick_time(24'hFFFFFF));
                if (p == 1 || $urandom_range(0, 3) != 0) push_cfg(CFG_DECAY, pick_time(24'hFFFFFF));
                if (p == 1 || $urandom_range(0, 3) != 0) push_cfg(CFG_SUSTAIN, pick_sustain());
                if (p == 1 || $urandom_range(0, 3) != 0) push_cfg(CFG_RELEASE, pick_time(24'hFFFFFF));
                if (p == 1 || $urandom_range(0, 3) != 0) begin
                    fast_t = pick_time(16'hFFFF);
                    push_cfg(CFG_FAST, {8'($urandom), fast_t[FAST_W-1:0]});
                end
                if ($urandom_range(0, 3) == 0) begin
                    push_cfg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                             CFG_DATA_W'($urandom));
                end
            end

            set_size = $urandom_range(1, 4);
            for (int k = 0; k < 4; k++) begin
                voice_set[k] = VOICE_W'($urandom_range(0, DEF_VOICES - 1));
            end
            for (int k = 0; k < set_size; k++) begin
                push_word(MODE_ON, voice_set[k]);
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                r = $urandom_range(0, 99);
                v = voice_set[$urandom_range(0, set_size - 1)];
                if (r < 7) begin
                    push_word(MODE_ON, v);
                end else if (r < 11) begin
                    push_word(MODE_OFF, v);
                end else if (r < 14) begin
                    push_word(MODE_FAST, v);
                end else if (r < 20) begin
                    push_word(MODE_W'($urandom_range(0, 3)),
                              VOICE_W'($urandom_range(0, DEF_VOICES - 1)));
                end else begin
                    push_word(MODE_TICK, v);
                end
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (pending_ops.size() != 0 || words_outstanding != 0 ||
                   i_in_valid || i_cfg_valid);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d result words never arrived", expected_results.size());
            failures++;
        end
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
